/* sv/mbet_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared widths, fixed point constants and types of the escape time pixel
// evaluator.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int INDEX_W   = 24;
    localparam int WIDTH_W   = 13;
    localparam int STEP_W    = 29;
    localparam int COORD_W   = 36;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_W     = 56;
    localparam int GRAY_W    = 8;
    localparam int ECOUNT_W  = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd3;

    localparam logic signed [COORD_W-1:0] ORIGIN_RESET = -36'sd536870912;
    localparam logic [STEP_W-1:0]         STEP_RESET   = 29'd1048576;
    localparam logic [WIDTH_W-1:0]        WIDTH_RESET  = 13'd1024;

    localparam logic signed [COORD_W-1:0] FOUR_Q28     = 36'sd1073741824;
    localparam logic signed [COORD_W-1:0] NEG_FOUR_Q28 = -36'sd1073741824;
    localparam logic [62:0]               SIXTEEN_Q56  = 63'h1000_0000_0000_0000;

    localparam logic signed [SUM_W-1:0] COORD_MAX = 56'sd34359738367;
    localparam logic signed [SUM_W-1:0] COORD_MIN = -56'sd34359738368;

    localparam logic [GRAY_W-1:0] GRAY_FULL = 8'd255;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef struct packed {
        logic               done;
        logic [INDEX_W-1:0] quotient;
        logic [WIDTH_W-1:0] remainder;
    } div_res_t;

endpackage

/* sv/mbet_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_div
// Restoring divider that splits a pixel index into row and column, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbet_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mbet_pkg::INDEX_W-1:0] dividend,
    input  logic [mbet_pkg::WIDTH_W-1:0] divisor,
    output mbet_pkg::div_res_t           res
);

    localparam int CNT_W = $clog2(mbet_pkg::INDEX_W + 1);

    logic [mbet_pkg::INDEX_W-1:0] quot_reg;
    logic [mbet_pkg::INDEX_W-1:0] quot_next;
    logic [mbet_pkg::WIDTH_W-1:0] rem_reg;
    logic [mbet_pkg::WIDTH_W-1:0] rem_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [mbet_pkg::WIDTH_W:0]   trial;
    logic                         fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[mbet_pkg::INDEX_W-1]};
        fits      = trial >= {1'b0, divisor};
        rem_next  = fits ? mbet_pkg::WIDTH_W'(trial - {1'b0, divisor})
                         : trial[mbet_pkg::WIDTH_W-1:0];
        quot_next = {quot_reg[mbet_pkg::INDEX_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(mbet_pkg::INDEX_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quot_reg;
    assign res.remainder = rem_reg;

endmodule

/* sv/mandelbrot_escape_time_pixel_top.sv */
`timescale 1ns / 1ps
// Each accepted item waits for the divider, then forms c, then runs its iterations (the escape
// count, or MAX_ITER-1 when none), and at last loads the result. A new item is taken only when
// idle, after the last result has been loaded; the single shared 36x36 multiplier is used three
// times per iteration.
// Reset clears the control state and loads the register reset values.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape time evaluator for one pixel of a Mandelbrot image in Q8.28 fixed
// point, built around one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top
#(
    parameter int MAX_ITER  = 100,
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  logic [mbet_pkg::INDEX_W-1:0]   pixel_index,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [mbet_pkg::GRAY_W-1:0]    gray_level,
    output logic [mbet_pkg::ECOUNT_W-1:0]  escape_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbet_pkg::COORD_W-1:0]   cfg_data
);

    localparam int IW        = $clog2(MAX_ITER + 1);
    localparam int GRAY_STEP = 255 / MAX_ITER;
    localparam int FB        = mbet_pkg::FRAC_BITS;
    localparam int CW        = mbet_pkg::COORD_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_MCR  = 4'd2;
    localparam logic [3:0] S_MCI  = 4'd3;
    localparam logic [3:0] S_ACI  = 4'd4;
    localparam logic [3:0] S_MRR  = 4'd5;
    localparam logic [3:0] S_MII  = 4'd6;
    localparam logic [3:0] S_MRI  = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]                   state_reg;
    logic [3:0]                   state_next;

    mbet_pkg::coord_t             origin_x_reg;
    mbet_pkg::coord_t             origin_y_reg;
    logic [mbet_pkg::STEP_W-1:0]  pixel_step_reg;
    logic [mbet_pkg::WIDTH_W-1:0] image_width_reg;
    logic [mbet_pkg::WIDTH_W-1:0] width_eff;

    mbet_pkg::div_res_t           div_res;
    logic                         accept;

    mbet_pkg::coord_t             mul_a;
    mbet_pkg::coord_t             mul_b;
    mbet_pkg::prod_t              mul_res;
    mbet_pkg::prod_t              prod_reg;
    mbet_pkg::prod_t              prr_reg;
    mbet_pkg::prod_t              pii_reg;
    mbet_pkg::prod_t              pri_reg;

    mbet_pkg::coord_t             cr_reg;
    mbet_pkg::coord_t             ci_reg;
    mbet_pkg::coord_t             zr_reg;
    mbet_pkg::coord_t             zi_reg;
    mbet_pkg::coord_t             c_sat;
    mbet_pkg::coord_t             origin_sel;
    logic signed [mbet_pkg::SUM_W-1:0] c_sum;

    mbet_pkg::prod_t              diff;
    logic [62:0]                  mag_sum;
    logic                         escaped;

    logic [IW-1:0]                n_reg;
    logic [IW-1:0]                count_reg;
    logic                         result_valid_reg;
    logic [mbet_pkg::GRAY_W-1:0]  gray_reg;
    logic [mbet_pkg::ECOUNT_W-1:0] ecount_reg;
    logic                         load_out;

    assign cfg_ready   = 1'b1;
    assign pixel_stall = (state_reg != S_IDLE);
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_eff = mbet_pkg::WIDTH_W'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = mbet_pkg::WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = image_width_reg;
        end
    end

    mbet_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (pixel_index),
        .divisor  (width_eff),
        .res      (div_res)
    );

    always_comb
    begin
        unique case (state_reg)
            S_MCR:
            begin
                mul_a = CW'(div_res.remainder);
                mul_b = CW'(pixel_step_reg);
            end
            S_MCI:
            begin
                mul_a = CW'(div_res.quotient);
                mul_b = CW'(pixel_step_reg);
            end
            S_MRR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_MII:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    always_comb
    begin
        origin_sel = (state_reg == S_MCI) ? origin_x_reg : origin_y_reg;
        c_sum      = mbet_pkg::SUM_W'(origin_sel) + $signed(prod_reg[mbet_pkg::SUM_W-1:0]);
        priority if (c_sum > mbet_pkg::COORD_MAX)
        begin
            c_sat = CW'(mbet_pkg::COORD_MAX);
        end
        else if (c_sum < mbet_pkg::COORD_MIN)
        begin
            c_sat = CW'(mbet_pkg::COORD_MIN);
        end
        else
        begin
            c_sat = CW'(c_sum);
        end
    end

    always_comb
    begin
        diff    = prr_reg - pii_reg;
        mag_sum = 63'(prr_reg[61:0]) + 63'(pii_reg[61:0]);
        escaped = (zr_reg > mbet_pkg::FOUR_Q28) || (zr_reg < mbet_pkg::NEG_FOUR_Q28)
               || (zi_reg > mbet_pkg::FOUR_Q28) || (zi_reg < mbet_pkg::NEG_FOUR_Q28)
               || (mag_sum > mbet_pkg::SIXTEEN_Q56);
    end

    assign load_out = (state_reg == S_OUT) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_DIV;
            S_DIV:  if (div_res.done) state_next = S_MCR;
            S_MCR:  state_next = S_MCI;
            S_MCI:  state_next = S_ACI;
            S_ACI:  state_next = S_MRR;
            S_MRR:  state_next = S_MII;
            S_MII:  state_next = S_MRI;
            S_MRI:  state_next = S_CHK;
            S_CHK:
            begin
                if (escaped || (n_reg == IW'(MAX_ITER - 1)))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MRR;
                end
            end
            S_OUT:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            origin_x_reg     <= mbet_pkg::ORIGIN_RESET;
            origin_y_reg     <= mbet_pkg::ORIGIN_RESET;
            pixel_step_reg   <= mbet_pkg::STEP_RESET;
            image_width_reg  <= mbet_pkg::WIDTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mbet_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                    mbet_pkg::REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                    mbet_pkg::REG_PIXEL_STEP:  pixel_step_reg  <= cfg_data[mbet_pkg::STEP_W-1:0];
                    mbet_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data[mbet_pkg::WIDTH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_MCR:
            begin
                prod_reg <= mul_res;
            end
            S_MCI:
            begin
                prod_reg <= mul_res;
                cr_reg   <= c_sat;
            end
            S_ACI:
            begin
                ci_reg <= c_sat;
                zr_reg <= cr_reg;
                zi_reg <= c_sat;
                n_reg  <= IW'(1);
            end
            S_MRR:
            begin
                prr_reg <= mul_res;
            end
            S_MII:
            begin
                pii_reg <= mul_res;
            end
            S_MRI:
            begin
                pri_reg <= mul_res;
            end
            S_CHK:
            begin
                if (escaped)
                begin
                    count_reg <= n_reg;
                end
                else if (n_reg == IW'(MAX_ITER - 1))
                begin
                    count_reg <= IW'(MAX_ITER);
                end
                else
                begin
                    zr_reg <= diff[FB+CW-1:FB] + cr_reg;
                    zi_reg <= pri_reg[FB+CW-2:FB-1] + ci_reg;
                    n_reg  <= n_reg + 1'b1;
                end
            end
            default: ;
        endcase
        if (load_out)
        begin
            gray_reg   <= (count_reg == IW'(MAX_ITER)) ? mbet_pkg::GRAY_FULL
                        : mbet_pkg::GRAY_W'(32'(count_reg) * GRAY_STEP);
            ecount_reg <= mbet_pkg::ECOUNT_W'(count_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign gray_level   = gray_reg;
    assign escape_count = ecount_reg;

endmodule
